>>> sv/sdpt_pkg.sv
// shared types, codes and defaults for the store distance predictor table
package sdpt_pkg;

  localparam int DEF_SET_IDX_W = 7;
  localparam int DEF_WAYS      = 4;
  localparam int DEF_TAG_W     = 16;
  localparam int DEF_TBL_CNT   = 8;

  localparam int ADDR_W  = 48;
  localparam int HIST_W  = 32;
  localparam int DIST_W  = 8;
  localparam int CONF_W  = 8;
  localparam int STAMP_W = 32;
  localparam int BYTES_W = 7;
  localparam int SHIFT_W = 4;
  localparam int SEL_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CONF_W-1:0]  RST_MAX_CONF  = 8'd15;
  localparam logic [SHIFT_W-1:0] RST_DEP_SHIFT = 4'd3;

  typedef enum logic [1:0] {
    REQ_LOOKUP   = 2'd0,
    REQ_TRAIN    = 2'd1,
    REQ_COMMIT   = 2'd2,
    REQ_PENALIZE = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_CONF  = 1'b0,
    CFG_DEP_SHIFT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
  } dp_stat_t;

endpackage

>>> sv/sdpt_ctrl.sv
// controller: clearing pass, request sequencing and result hold
module sdpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sdpt_pkg::dp_cmd_t cmd,
  input  sdpt_pkg::dp_stat_t stat
);
  import sdpt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_ready) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready)
    else $error("input taken during clearing pass");
  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed request gave no result");
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_EXEC)
    else $error("accepted request not executed");
  a_no_exec_over_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || out_ready))
    else $error("result overwritten while held");
`endif

endmodule

>>> sv/sdpt_datapath.sv
// datapath: hashing, set memory, way match, victim choice and update
module sdpt_datapath #(
  parameter int SET_IDX_W = sdpt_pkg::DEF_SET_IDX_W,
  parameter int WAYS      = sdpt_pkg::DEF_WAYS,
  parameter int TAG_W     = sdpt_pkg::DEF_TAG_W,
  parameter int TBL_CNT   = sdpt_pkg::DEF_TBL_CNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sdpt_pkg::dp_cmd_t               cmd,
  output sdpt_pkg::dp_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [sdpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]                      in_req_type,
  input  logic [sdpt_pkg::SEL_W-1:0]      in_table_select,
  input  logic [sdpt_pkg::ADDR_W-1:0]     in_load_pc,
  input  logic [sdpt_pkg::HIST_W-1:0]     in_history_hash,
  input  logic [sdpt_pkg::DIST_W-1:0]     in_store_distance,
  input  logic [sdpt_pkg::ADDR_W-1:0]     in_load_address,
  input  logic [sdpt_pkg::BYTES_W-1:0]    in_load_bytes,
  input  logic [sdpt_pkg::ADDR_W-1:0]     in_store_address,
  input  logic [sdpt_pkg::BYTES_W-1:0]    in_store_bytes,
  output logic [sdpt_pkg::DIST_W-1:0]     out_predicted_distance,
  output logic                            out_prediction_valid,
  output logic                            out_entry_found,
  output logic                            out_ranges_disjoint
);
  import sdpt_pkg::*;

  localparam int ROWS     = TBL_CNT << SET_IDX_W;
  localparam int ROW_BITS = $clog2(ROWS);
  localparam int EW       = TAG_W + DIST_W + CONF_W + STAMP_W;
  localparam int ROW_W    = EW * WAYS;
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EXT_W    = ADDR_W + 1;

  logic [ROW_W-1:0] mem [ROWS];

  logic [CONF_W-1:0]  max_conf_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [STAMP_W-1:0] stamp_cnt_r;
  logic [ROW_BITS-1:0] clr_cnt_r;

  logic [ROW_W-1:0]    rd_r;
  req_t                req_r;
  logic [ROW_BITS-1:0] row_r;
  logic [TAG_W-1:0]    tag_r;
  logic [DIST_W-1:0]   dist_r;
  logic                ok_r;
  logic                disj_r;

  logic [DIST_W-1:0] pd_r;
  logic              pv_r, fnd_r, rd_disj_r;

  // request hashing and overlap check at transfer
  logic [ADDR_W-1:0]    hv1, hv2;
  logic [SET_IDX_W-1:0] set_h;
  logic [TAG_W-1:0]     tag_h;
  logic [ROW_BITS-1:0]  in_row;
  logic                 in_ok;
  logic [BYTES_W-1:0]   lb_eff, sb_eff;
  logic [EXT_W-1:0]     l1, l2, s1, s2;
  logic                 in_disj;

  always_comb begin
    hv1 = in_load_pc ^ (in_load_pc >> 2) ^ (in_load_pc >> 5)
          ^ {{(ADDR_W-HIST_W){1'b0}}, in_history_hash};
    hv2 = in_load_pc ^ (in_load_pc >> 3) ^ (in_load_pc >> 7)
          ^ {{(ADDR_W-HIST_W){1'b0}}, in_history_hash};
    set_h = '0;
    tag_h = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      set_h[i % SET_IDX_W] = set_h[i % SET_IDX_W] ^ hv1[i];
      tag_h[i % TAG_W] = tag_h[i % TAG_W] ^ hv2[i];
    end
    in_row = ROW_BITS'((32'(in_table_select) << SET_IDX_W) + 32'(set_h));
    in_ok  = 32'(in_table_select) < TBL_CNT;
    lb_eff = (in_load_bytes == '0) ? BYTES_W'(1) : in_load_bytes;
    sb_eff = (in_store_bytes == '0) ? BYTES_W'(1) : in_store_bytes;
    l1 = {1'b0, in_load_address} >> shift_r;
    s1 = {1'b0, in_store_address} >> shift_r;
    l2 = ({1'b0, in_load_address} + EXT_W'(lb_eff) - EXT_W'(1)) >> shift_r;
    s2 = ({1'b0, in_store_address} + EXT_W'(sb_eff) - EXT_W'(1)) >> shift_r;
    in_disj = !((s2 >= l1) && (s1 <= l2));
  end

  // way match and victim choice
  logic [TAG_W-1:0]    w_tag   [WAYS];
  logic [DIST_W-1:0]   w_dist  [WAYS];
  logic [CONF_W-1:0]   w_conf  [WAYS];
  logic [STAMP_W-1:0]  w_stamp [WAYS];
  logic [WAY_BITS-1:0] hit, vic, tgt;
  logic                found;
  logic [TAG_W-1:0]    tag_n;
  logic [DIST_W-1:0]   dist_n;
  logic [CONF_W-1:0]   conf_n;
  logic                do_wr, wr_en, pv_n;
  logic [ROW_W-1:0]    new_row;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      w_tag[w]   = rd_r[w*EW +: TAG_W];
      w_dist[w]  = rd_r[w*EW + TAG_W +: DIST_W];
      w_conf[w]  = rd_r[w*EW + TAG_W + DIST_W +: CONF_W];
      w_stamp[w] = rd_r[w*EW + TAG_W + DIST_W + CONF_W +: STAMP_W];
    end
    found = 1'b0;
    hit   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (w_tag[w] == tag_r) begin
        found = 1'b1;
        hit   = WAY_BITS'(w);
      end
    end
    vic = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (w_stamp[w] < w_stamp[vic]) vic = WAY_BITS'(w);
    end

    tgt    = hit;
    tag_n  = w_tag[hit];
    dist_n = w_dist[hit];
    conf_n = w_conf[hit];
    do_wr  = 1'b0;
    pv_n   = 1'b0;
    case (req_r)
      REQ_LOOKUP: begin
        pv_n  = found && (w_conf[hit] != '0) && (w_dist[hit] != '0);
        do_wr = pv_n;
      end
      REQ_TRAIN: begin
        tgt    = found ? hit : vic;
        tag_n  = tag_r;
        dist_n = dist_r;
        conf_n = max_conf_r;
        do_wr  = 1'b1;
      end
      REQ_COMMIT: begin
        do_wr  = found && (w_conf[hit] != '0);
        conf_n = disj_r ? (w_conf[hit] - CONF_W'(1)) : max_conf_r;
      end
      REQ_PENALIZE: begin
        do_wr  = found && (w_conf[hit] != '0);
        conf_n = w_conf[hit] - CONF_W'(1);
      end
      default: do_wr = 1'b0;
    endcase
    wr_en   = cmd.exec && ok_r && do_wr;
    new_row = rd_r;
    new_row[tgt*EW +: EW] = {stamp_cnt_r, conf_n, dist_n, tag_n};
  end

  // set memory
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[row_r] <= new_row;
    end
    if (cmd.load) rd_r <= mem[in_row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_conf_r  <= RST_MAX_CONF;
      shift_r     <= RST_DEP_SHIFT;
      stamp_cnt_r <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MAX_CONF:  max_conf_r <= cfg_wdata[CONF_W-1:0];
          CFG_DEP_SHIFT: shift_r    <= cfg_wdata[SHIFT_W-1:0];
          default:       shift_r    <= shift_r;
        endcase
      end
      if (wr_en) stamp_cnt_r <= stamp_cnt_r + STAMP_W'(1);
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + ROW_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req_t'(in_req_type);
      row_r  <= in_row;
      tag_r  <= tag_h;
      dist_r <= in_store_distance;
      ok_r   <= in_ok;
      disj_r <= in_disj;
    end
    if (cmd.exec) begin
      pd_r      <= (ok_r && pv_n) ? w_dist[hit] : '0;
      pv_r      <= ok_r && pv_n;
      fnd_r     <= ok_r && found;
      rd_disj_r <= ok_r && (req_r == REQ_COMMIT) && disj_r;
    end
  end

  assign stat.clear_done        = cmd.clear && (clr_cnt_r == ROW_BITS'(ROWS - 1));
  assign out_predicted_distance = pd_r;
  assign out_prediction_valid   = pv_r;
  assign out_entry_found        = fnd_r;
  assign out_ranges_disjoint    = rd_disj_r;

`ifndef SYNTHESIS
  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> !wr_en)
    else $error("entry update during clearing pass");
  a_stamp_advances: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> stamp_cnt_r == $past(stamp_cnt_r) + STAMP_W'(1))
    else $error("stamp counter did not advance on update");
  a_bad_table_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !ok_r) |-> !wr_en)
    else $error("update for table out of range");
`endif

endmodule

>>> sv/store_distance_predictor_table_core.sv
// top level of the store distance predictor table
// usage:
//   input channel in_valid/in_ready carries one request (lookup, train,
//   commit check or penalize) for one table; the result channel
//   out_valid/out_ready returns exactly one result per request.
//   cfg_we writes max_confidence (index 0) or dep_check_shift (index 1)
//   in the same cycle; the user must write them only while the block is idle, a rule the block leaves to the user.
// timing:
//   a request is taken in the idle state, the set row is read at that
//   transfer and written back in the execute state, when the result is
//   loaded into the output register; the next request is taken only
//   after that write-back, once the block is idle again.
// reset:
//   rst_n is synchronous; afterwards a clearing pass zeroes the memory
//   one row a cycle, all TBL_CNT * 2^SET_IDX_W rows (1024 by default),
//   with in_ready low; configuration writes are taken during it.
// stall:
//   a result waits in the output register while out_ready is low; the next
//   request may be taken but is not finished until that result is taken.
module store_distance_predictor_table_core #(
  parameter int SET_IDX_W = sdpt_pkg::DEF_SET_IDX_W,
  parameter int WAYS      = sdpt_pkg::DEF_WAYS,
  parameter int TAG_W     = sdpt_pkg::DEF_TAG_W,
  parameter int TBL_CNT   = sdpt_pkg::DEF_TBL_CNT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sdpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_req_type,
  input  logic [sdpt_pkg::SEL_W-1:0]      in_table_select,
  input  logic [sdpt_pkg::ADDR_W-1:0]     in_load_pc,
  input  logic [sdpt_pkg::HIST_W-1:0]     in_history_hash,
  input  logic [sdpt_pkg::DIST_W-1:0]     in_store_distance,
  input  logic [sdpt_pkg::ADDR_W-1:0]     in_load_address,
  input  logic [sdpt_pkg::BYTES_W-1:0]    in_load_bytes,
  input  logic [sdpt_pkg::ADDR_W-1:0]     in_store_address,
  input  logic [sdpt_pkg::BYTES_W-1:0]    in_store_bytes,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sdpt_pkg::DIST_W-1:0]     out_predicted_distance,
  output logic                            out_prediction_valid,
  output logic                            out_entry_found,
  output logic                            out_ranges_disjoint
);
  import sdpt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sdpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sdpt_datapath #(
    .SET_IDX_W (SET_IDX_W),
    .WAYS      (WAYS),
    .TAG_W     (TAG_W),
    .TBL_CNT   (TBL_CNT)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_req_type            (in_req_type),
    .in_table_select        (in_table_select),
    .in_load_pc             (in_load_pc),
    .in_history_hash        (in_history_hash),
    .in_store_distance      (in_store_distance),
    .in_load_address        (in_load_address),
    .in_load_bytes          (in_load_bytes),
    .in_store_address       (in_store_address),
    .in_store_bytes         (in_store_bytes),
    .out_predicted_distance (out_predicted_distance),
    .out_prediction_valid   (out_prediction_valid),
    .out_entry_found        (out_entry_found),
    .out_ranges_disjoint    (out_ranges_disjoint)
  );

endmodule
